// File: rtl/lcd_mode_line_timing_macros.svh
// Assertion macros shared by the LCD mode and line timing checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef LCD_MODE_LINE_TIMING_MACROS_SVH
`define LCD_MODE_LINE_TIMING_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define LMLT_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("lmlt: invariant violated");

// Same-cycle implication.
`define LMLT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lmlt: implication violated");

// Next-cycle implication.
`define LMLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lmlt: next-cycle implication violated");

`endif

// File: rtl/lmlt_pkg.sv
// Types and constants of the LCD mode and line timing block.
// Depends on nothing; used by the interfaces and all RTL modules.
`default_nettype none

package lmlt_pkg;

	localparam int CNT_W      = 10;
	localparam int LINE_W     = 8;
	localparam int CYC_W      = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	localparam logic [CNT_W-1:0]  CYC_OAM           = 10'd80;
	localparam logic [CNT_W-1:0]  CYC_XFER          = 10'd172;
	localparam logic [CNT_W-1:0]  CYC_HBLANK        = 10'd204;
	localparam logic [CNT_W-1:0]  CYC_LINE          = 10'd456;
	localparam logic [LINE_W-1:0] FIRST_VBLANK_LINE = 8'd144;
	localparam logic [LINE_W-1:0] LAST_LINE         = 8'd153;

	typedef enum logic [1:0] {
		PHASE_HBLANK = 2'd0,
		PHASE_VBLANK = 2'd1,
		PHASE_OAM    = 2'd2,
		PHASE_XFER   = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LCD_ENABLE   = 3'd0,
		REG_LINE_COMPARE = 3'd1,
		REG_IRQ_HBLANK   = 3'd2,
		REG_IRQ_VBLANK   = 3'd3,
		REG_IRQ_OAM      = 3'd4,
		REG_IRQ_MATCH    = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic              lcd_enable;
		logic [LINE_W-1:0] line_compare;
		logic              irq_on_hblank;
		logic              irq_on_vblank_mode;
		logic              irq_on_oam;
		logic              irq_on_match;
	} cfg_t;

	typedef struct packed {
		mode_t             lcd_mode;
		logic [LINE_W-1:0] current_line;
		logic              match_flag;
		logic              vblank_request;
		logic              lcd_status_request;
	} res_t;

endpackage

`default_nettype wire

// File: rtl/lmlt_cycles_if.sv
// Input channel: one request carries the elapsed machine cycle count.
// Depends on lmlt_pkg.
`default_nettype none

interface lmlt_cycles_if;
	logic                          valid;
	logic                          ready;
	logic [lmlt_pkg::CYC_W-1:0]    elapsed_cycles;

	modport source (output valid, output elapsed_cycles, input ready);
	modport sink (input valid, input elapsed_cycles, output ready);
endinterface

`default_nettype wire

// File: rtl/lmlt_result_if.sv
// Output channel: one request carries mode, line, match flag and interrupt requests.
// Depends on lmlt_pkg.
`default_nettype none

interface lmlt_result_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    lcd_mode;
	logic [lmlt_pkg::LINE_W-1:0]   current_line;
	logic                          match_flag;
	logic                          vblank_request;
	logic                          lcd_status_request;

	modport source (output valid, output lcd_mode, output current_line, output match_flag,
		output vblank_request, output lcd_status_request, input ready);
	modport sink (input valid, input lcd_mode, input current_line, input match_flag,
		input vblank_request, input lcd_status_request, output ready);
endinterface

`default_nettype wire

// File: rtl/lmlt_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on lmlt_pkg.
`default_nettype none

interface lmlt_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [lmlt_pkg::CFG_IDX_W-1:0]   index;
	logic [lmlt_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/lmlt_cfg_regs.sv
// Configuration register file of the LCD mode and line timing block.
// Depends on lmlt_pkg and lmlt_cfg_if.
`default_nettype none

module lmlt_cfg_regs (
	input  wire logic          clk,
	input  wire logic          arst_n,
	lmlt_cfg_if.sink           cfg,
	output lmlt_pkg::cfg_t     regs
);

	lmlt_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (cfg.valid) begin
			case (lmlt_pkg::cfg_idx_t'(cfg.index))
				lmlt_pkg::REG_LCD_ENABLE:   regs_q.lcd_enable         <= cfg.data[0];
				lmlt_pkg::REG_LINE_COMPARE: regs_q.line_compare       <= cfg.data;
				lmlt_pkg::REG_IRQ_HBLANK:   regs_q.irq_on_hblank      <= cfg.data[0];
				lmlt_pkg::REG_IRQ_VBLANK:   regs_q.irq_on_vblank_mode <= cfg.data[0];
				lmlt_pkg::REG_IRQ_OAM:      regs_q.irq_on_oam         <= cfg.data[0];
				lmlt_pkg::REG_IRQ_MATCH:    regs_q.irq_on_match       <= cfg.data[0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/lmlt_core.sv
// Timing state (dot counter, mode, line, match) and its one-step update.
// Depends on lmlt_pkg.
`default_nettype none

module lmlt_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        advance,
	input  wire logic [lmlt_pkg::CYC_W-1:0]  cyc,
	input  wire lmlt_pkg::cfg_t              cfg,
	output lmlt_pkg::res_t                   res
);

	logic [lmlt_pkg::CNT_W-1:0]  dot_q, dot_d;
	lmlt_pkg::mode_t             mode_q, mode_d;
	logic [lmlt_pkg::LINE_W-1:0] line_q, line_d;
	logic                        match_q, match_d;

	logic [lmlt_pkg::CNT_W:0]    sum;
	logic [lmlt_pkg::CNT_W-1:0]  sat;
	logic [lmlt_pkg::LINE_W-1:0] line_inc;
	logic                        do_cmp;
	logic                        vreq;
	logic                        lreq;

	always_comb begin
		sum      = {1'b0, dot_q} + {{(lmlt_pkg::CNT_W + 1 - lmlt_pkg::CYC_W){1'b0}}, cyc};
		// saturate at the counter's top
		sat      = sum[lmlt_pkg::CNT_W] ? '1 : sum[lmlt_pkg::CNT_W-1:0];
		line_inc = line_q + 8'd1;
		dot_d    = dot_q;
		mode_d   = mode_q;
		line_d   = line_q;
		match_d  = match_q;
		do_cmp   = 1'b0;
		vreq     = 1'b0;
		lreq     = 1'b0;

		if (!cfg.lcd_enable) begin
			dot_d  = '0;
			line_d = '0;
			mode_d = lmlt_pkg::PHASE_HBLANK;
		end else begin
			dot_d = sat;
			case (mode_q)
				lmlt_pkg::PHASE_HBLANK: begin
					if (sat >= lmlt_pkg::CYC_HBLANK) begin
						line_d = line_inc;
						dot_d  = sat - lmlt_pkg::CYC_HBLANK;
						do_cmp = 1'b1;
						if (line_inc != lmlt_pkg::FIRST_VBLANK_LINE) begin
							mode_d = lmlt_pkg::PHASE_OAM;
							lreq   = cfg.irq_on_oam;
						end else begin
							mode_d = lmlt_pkg::PHASE_VBLANK;
							vreq   = 1'b1;
							lreq   = cfg.irq_on_vblank_mode;
						end
					end
				end
				lmlt_pkg::PHASE_VBLANK: begin
					if (sat >= lmlt_pkg::CYC_LINE) begin
						dot_d  = sat - lmlt_pkg::CYC_LINE;
						do_cmp = 1'b1;
						// wrap to the top of the frame
						if (line_inc > lmlt_pkg::LAST_LINE) begin
							line_d = '0;
							mode_d = lmlt_pkg::PHASE_OAM;
							lreq   = cfg.irq_on_oam;
						end else begin
							line_d = line_inc;
						end
					end
				end
				lmlt_pkg::PHASE_OAM: begin
					if (sat >= lmlt_pkg::CYC_OAM) begin
						dot_d  = sat - lmlt_pkg::CYC_OAM;
						mode_d = lmlt_pkg::PHASE_XFER;
					end
				end
				lmlt_pkg::PHASE_XFER: begin
					if (sat >= lmlt_pkg::CYC_XFER) begin
						dot_d  = sat - lmlt_pkg::CYC_XFER;
						mode_d = lmlt_pkg::PHASE_HBLANK;
						lreq   = cfg.irq_on_hblank;
					end
				end
				default: begin
					mode_d = lmlt_pkg::PHASE_HBLANK;
				end
			endcase

			if (do_cmp) begin
				match_d = (line_d == cfg.line_compare);
				if (match_d && cfg.irq_on_match) begin
					lreq = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q   <= '0;
			mode_q  <= lmlt_pkg::PHASE_HBLANK;
			line_q  <= '0;
			match_q <= 1'b0;
		end else if (advance) begin
			dot_q   <= dot_d;
			mode_q  <= mode_d;
			line_q  <= line_d;
			match_q <= match_d;
		end
	end

	assign res = '{
		lcd_mode:           mode_d,
		current_line:       line_d,
		match_flag:         match_d,
		vblank_request:     vreq,
		lcd_status_request: lreq
	};

endmodule

`default_nettype wire

// File: rtl/lcd_mode_line_timing.sv
// LCD mode and line timing block.
//
// cycles: one request per update carries the machine cycles elapsed since
// the previous one. Each request yields exactly one result request on
// result: the mode, the line, the line-compare flag, and the vblank and
// LCD status interrupt requests raised by that update.
// cfg: register writes (index 0 enable, 1 line compare, 2..5 interrupt
// enables), taken in any cycle; write only while no request is in flight.
//
// A request waits in the input stage, then its result is registered.
// Throughput: one request per cycle while result.ready holds, set by the
// update of the dot counter, mode and line registers between the input
// stage and the result register.
// Reset: control, timing and config registers clear; timing state starts
// at line 0 in horizontal blank with the display off.
// Stall: while result is held, the pending result stays put and one more
// request still enters the input stage; then cycles.ready drops until the
// result is taken.
//
// Depends on lmlt_pkg, the lmlt_*_if interfaces, lmlt_cfg_regs, lmlt_core.
`default_nettype none

module lcd_mode_line_timing (
	input  wire logic      clk,
	input  wire logic      arst_n,
	lmlt_cycles_if.sink    cycles,
	lmlt_result_if.source  result,
	lmlt_cfg_if.sink       cfg
);

	logic                        valid_s1;
	logic [lmlt_pkg::CYC_W-1:0]  cyc_s1;
	logic                        out_valid_q;
	lmlt_pkg::res_t              res_q;
	lmlt_pkg::res_t              res_next;
	lmlt_pkg::cfg_t              regs;
	logic                        advance;

	lmlt_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	lmlt_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.cyc     (cyc_s1),
		.cfg     (regs),
		.res     (res_next)
	);

	// move the staged request into the result register when it is free
	assign advance      = valid_s1 && (!out_valid_q || result.ready);
	assign cycles.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cycles.valid && cycles.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cycles.valid && cycles.ready) begin
			cyc_s1 <= cycles.elapsed_cycles;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign result.valid              = out_valid_q;
	assign result.lcd_mode           = res_q.lcd_mode;
	assign result.current_line       = res_q.current_line;
	assign result.match_flag         = res_q.match_flag;
	assign result.vblank_request     = res_q.vblank_request;
	assign result.lcd_status_request = res_q.lcd_status_request;

endmodule

`default_nettype wire

// File: rtl/lmlt_checker.sv
// Port-level checker for the LCD mode and line timing block, with its bind.
// Depends on lmlt_pkg and lcd_mode_line_timing_macros.svh.
`default_nettype none
`include "lcd_mode_line_timing_macros.svh"

module lmlt_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire logic [1:0]                   lcd_mode,
	input wire logic [lmlt_pkg::LINE_W-1:0]  current_line,
	input wire logic                         vblank_request
);

	logic                          in_vblank;
	logic                          stalled;
	logic [lmlt_pkg::LINE_W+1:0]   status;
	logic                          lower_frame;
	logic                          entry_ok;

	assign in_vblank   = (lcd_mode == lmlt_pkg::PHASE_VBLANK);
	assign stalled     = out_valid && !out_ready;
	assign status      = {lcd_mode, current_line};
	assign lower_frame = (current_line >= lmlt_pkg::FIRST_VBLANK_LINE);
	assign entry_ok    = in_vblank && (current_line == lmlt_pkg::FIRST_VBLANK_LINE);

	// hold a stalled result
	`LMLT_ASSERT_NEXT(a_stall_hold, clk, arst_n, stalled, out_valid && $stable(status))
	`LMLT_ASSERT_IMPL(a_line_range, clk, arst_n, out_valid, current_line <= lmlt_pkg::LAST_LINE)
	// vertical blank only covers the bottom lines of the frame
	`LMLT_ASSERT_IMPL(a_vblank_lines, clk, arst_n, out_valid && in_vblank, lower_frame)
	`LMLT_ASSERT_IMPL(a_vblank_entry, clk, arst_n, out_valid && vblank_request, entry_ok)

endmodule

bind lcd_mode_line_timing lmlt_checker u_lmlt_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (result.valid),
	.out_ready      (result.ready),
	.lcd_mode       (result.lcd_mode),
	.current_line   (result.current_line),
	.vblank_request (result.vblank_request)
);

`default_nettype wire
